FILE: rtl/core/wd_pkg.sv
package wd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int EVERY_BITS = 10;
  localparam int WINDOW_BITS = 16;
  localparam int MODE_BITS = 3;
  localparam int AGG_BITS = VALUE_BITS + COUNT_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EVERY_N = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MS = 2'd2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic signed [AGG_BITS-1:0] VAL_MAX_EXT =
    {{(AGG_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [AGG_BITS-1:0] VAL_MIN_EXT =
    {{(AGG_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PASS = 3'd0,
    MODE_NTH  = 3'd1,
    MODE_AVG  = 3'd2,
    MODE_MAX  = 3'd3,
    MODE_MIN  = 3'd4,
    MODE_LAST = 3'd5
  } wd_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } wd_back_state_t;

  // one result to be produced by the back end
  typedef struct packed {
    logic [TIME_BITS-1:0]       tstamp;
    logic signed [AGG_BITS-1:0] agg;
    logic [COUNT_BITS-1:0]      cnt;
    logic                       avg;
    logic                       ovf;
    logic                       last;
  } wd_cmd_t;

endpackage

FILE: rtl/core/wd_in_if.sv
interface wd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [wd_pkg::TIME_BITS-1:0]         sample_time;
  logic signed [wd_pkg::VALUE_BITS-1:0] sample_value;
  logic                                 series_end;

  modport source (output valid, output sample_time, output sample_value, output series_end,
                  input ready);
  modport sink (input valid, input sample_time, input sample_value, input series_end,
                output ready);
endinterface

FILE: rtl/core/wd_out_if.sv
interface wd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [wd_pkg::TIME_BITS-1:0]         out_time;
  logic signed [wd_pkg::VALUE_BITS-1:0] out_value;
  logic                                 out_last;
  logic                                 count_overflow;

  modport source (output valid, output out_time, output out_value, output out_last,
                  output count_overflow, input ready);
  modport sink (input valid, input out_time, input out_value, input out_last,
                input count_overflow, output ready);
endinterface

FILE: rtl/core/wd_front.sv
module wd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [wd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  wd_in_if.sink                              samples,
  output wd_pkg::wd_cmd_t                    cmd,
  output logic                               cmd_valid,
  input  logic                               cmd_room
);

  wd_pkg::wd_mode_t                         mode;
  logic [wd_pkg::EVERY_BITS-1:0]            every_n;
  logic [wd_pkg::WINDOW_BITS-1:0]           window_ms;

  logic                                     window_open;
  logic [wd_pkg::TIME_BITS-1:0]             window_start;
  logic signed [wd_pkg::AGG_BITS-1:0]       aggregate;
  logic [wd_pkg::COUNT_BITS-1:0]            sample_count;
  logic                                     overflowed;
  logic [wd_pkg::EVERY_BITS-1:0]            skip_index;

  logic                                     window_open_next;
  logic [wd_pkg::TIME_BITS-1:0]             window_start_next;
  logic signed [wd_pkg::AGG_BITS-1:0]       aggregate_next;
  logic [wd_pkg::COUNT_BITS-1:0]            sample_count_next;
  logic                                     overflowed_next;
  logic [wd_pkg::EVERY_BITS-1:0]            skip_index_next;

  logic                                     pend_valid;
  wd_pkg::wd_cmd_t                          pend;

  logic                                     accept;
  logic                                     a_valid;
  logic                                     b_valid;
  wd_pkg::wd_cmd_t                          cmd_a;
  wd_pkg::wd_cmd_t                          cmd_b;

  logic signed [wd_pkg::AGG_BITS-1:0]       v_ext;
  logic [wd_pkg::TIME_BITS:0]               window_end;
  logic                                     closes;
  logic [wd_pkg::TIME_BITS-1:0]             half_window;
  logic [wd_pkg::EVERY_BITS-1:0]            limit;
  logic [wd_pkg::EVERY_BITS:0]              skip_inc;
  logic                                     is_avg;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = !pend_valid && cmd_room;

  assign v_ext = {{(wd_pkg::AGG_BITS-wd_pkg::VALUE_BITS){samples.sample_value[
                   wd_pkg::VALUE_BITS-1]}}, samples.sample_value};
  assign window_end = {1'b0, window_start}
                    + {{(wd_pkg::TIME_BITS+1-wd_pkg::WINDOW_BITS){1'b0}}, window_ms};
  assign closes = window_open && ({1'b0, samples.sample_time} >= window_end);
  assign half_window = {{(wd_pkg::TIME_BITS-wd_pkg::WINDOW_BITS+1){1'b0}},
                        window_ms[wd_pkg::WINDOW_BITS-1:1]};
  assign limit = (every_n == '0) ? wd_pkg::EVERY_BITS'(1) : every_n;
  assign skip_inc = {1'b0, skip_index} + (wd_pkg::EVERY_BITS+1)'(1);
  assign is_avg = (mode == wd_pkg::MODE_AVG);

  always_comb begin
    window_open_next  = window_open;
    window_start_next = window_start;
    aggregate_next    = aggregate;
    sample_count_next = sample_count;
    overflowed_next   = overflowed;
    skip_index_next   = skip_index;
    a_valid = 1'b0;
    b_valid = 1'b0;

    // plain sample beat by default
    cmd_a.tstamp = samples.sample_time;
    cmd_a.agg    = v_ext;
    cmd_a.cnt    = wd_pkg::COUNT_BITS'(1);
    cmd_a.avg    = 1'b0;
    cmd_a.ovf    = 1'b0;
    cmd_a.last   = samples.series_end;

    unique case (mode)
      wd_pkg::MODE_AVG, wd_pkg::MODE_MAX, wd_pkg::MODE_MIN, wd_pkg::MODE_LAST: begin
        // closing result reads the old window
        cmd_a.tstamp = window_start + half_window;
        cmd_a.agg    = aggregate;
        cmd_a.cnt    = sample_count;
        cmd_a.avg    = is_avg;
        cmd_a.ovf    = is_avg && overflowed;
        cmd_a.last   = 1'b0;
        a_valid      = closes;
        if (!window_open || closes) begin
          window_open_next  = 1'b1;
          window_start_next = samples.sample_time;
          aggregate_next    = v_ext;
          sample_count_next = wd_pkg::COUNT_BITS'(1);
          overflowed_next   = 1'b0;
        end else begin
          unique case (mode)
            wd_pkg::MODE_AVG: begin
              if (sample_count >= wd_pkg::CNT_MAX) begin
                overflowed_next = 1'b1;
              end else begin
                aggregate_next    = aggregate + v_ext;
                sample_count_next = sample_count + wd_pkg::COUNT_BITS'(1);
              end
            end
            wd_pkg::MODE_MAX: begin
              if (v_ext > aggregate) aggregate_next = v_ext;
            end
            wd_pkg::MODE_MIN: begin
              if (v_ext < aggregate) aggregate_next = v_ext;
            end
            default: begin
              aggregate_next = v_ext;
            end
          endcase
        end
        b_valid = samples.series_end;
        if (samples.series_end) window_open_next = 1'b0;
      end
      wd_pkg::MODE_NTH: begin
        a_valid = (skip_index == '0);
        skip_index_next = (skip_inc >= {1'b0, limit}) ? '0
                        : skip_inc[wd_pkg::EVERY_BITS-1:0];
        if (samples.series_end) begin
          skip_index_next  = '0;
          window_open_next = 1'b0;
        end
      end
      default: begin
        a_valid = 1'b1;
        if (samples.series_end) begin
          skip_index_next  = '0;
          window_open_next = 1'b0;
        end
      end
    endcase

    // flush result reads the window after this sample
    cmd_b.tstamp = window_start_next + half_window;
    cmd_b.agg    = aggregate_next;
    cmd_b.cnt    = sample_count_next;
    cmd_b.avg    = is_avg;
    cmd_b.ovf    = is_avg && overflowed_next;
    cmd_b.last   = 1'b1;
  end

  assign cmd_valid = cmd_room && (pend_valid || (accept && (a_valid || b_valid)));
  assign cmd = pend_valid ? pend : (a_valid ? cmd_a : cmd_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= wd_pkg::MODE_PASS;
      every_n      <= wd_pkg::EVERY_BITS'(10);
      window_ms    <= wd_pkg::WINDOW_BITS'(1000);
      window_open  <= 1'b0;
      window_start <= '0;
      aggregate    <= '0;
      sample_count <= '0;
      overflowed   <= 1'b0;
      skip_index   <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          wd_pkg::CFG_MODE:      mode <= wd_pkg::wd_mode_t'(cfg_data[wd_pkg::MODE_BITS-1:0]);
          wd_pkg::CFG_EVERY_N:   every_n <= cfg_data[wd_pkg::EVERY_BITS-1:0];
          wd_pkg::CFG_WINDOW_MS: window_ms <= cfg_data[wd_pkg::WINDOW_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        window_open  <= window_open_next;
        window_start <= window_start_next;
        aggregate    <= aggregate_next;
        sample_count <= sample_count_next;
        overflowed   <= overflowed_next;
        skip_index   <= skip_index_next;
      end
      // second result of a beat waits here until the queue has room
      if (pend_valid && cmd_room) begin
        pend_valid <= 1'b0;
      end else if (accept && a_valid && b_valid) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && a_valid && b_valid) pend <= cmd_b;
  end

endmodule

FILE: rtl/core/wd_fifo.sv
module wd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wd_pkg::wd_cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output wd_pkg::wd_cmd_t pop_data,
  output logic            empty
);

  localparam int PTR_BITS = $clog2(wd_pkg::FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(wd_pkg::FIFO_DEPTH + 1);

  wd_pkg::wd_cmd_t       entries [wd_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   fill;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (fill == CNT_BITS'(wd_pkg::FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(wd_pkg::FIFO_DEPTH - 1)) ? '0
                : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(wd_pkg::FIFO_DEPTH - 1)) ? '0
                : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/core/wd_back.sv
module wd_back (
  input  logic            clk,
  input  logic            rst,
  input  wd_pkg::wd_cmd_t head,
  input  logic            head_empty,
  output logic            pop,
  wd_out_if.source        results
);

  localparam int STEP_BITS = $clog2(wd_pkg::AGG_BITS);

  wd_pkg::wd_back_state_t              state;
  wd_pkg::wd_back_state_t              state_next;

  logic [wd_pkg::AGG_BITS-1:0]         mag;
  logic [wd_pkg::COUNT_BITS-1:0]       rem;
  logic [wd_pkg::COUNT_BITS-1:0]       divisor;
  logic                                neg;
  logic [STEP_BITS-1:0]                step;
  logic [wd_pkg::TIME_BITS-1:0]        hold_time;
  logic                                hold_ovf;
  logic                                hold_last;

  logic                                out_valid;
  logic                                out_free;
  logic                                load_direct;
  logic                                load_div;
  logic                                start_div;

  logic [wd_pkg::COUNT_BITS:0]         rem_shift;
  logic                                q_bit;
  logic signed [wd_pkg::AGG_BITS-1:0]  quotient;

  function automatic logic signed [wd_pkg::VALUE_BITS-1:0] clamp_value(
    input logic signed [wd_pkg::AGG_BITS-1:0] x
  );
    logic signed [wd_pkg::AGG_BITS-1:0] r;
    r = x;
    if (x > wd_pkg::VAL_MAX_EXT) r = wd_pkg::VAL_MAX_EXT;
    if (x < wd_pkg::VAL_MIN_EXT) r = wd_pkg::VAL_MIN_EXT;
    return r[wd_pkg::VALUE_BITS-1:0];
  endfunction

  assign out_free = !out_valid || results.ready;
  assign results.valid = out_valid;

  // restoring division, one quotient bit per cycle shifted into mag
  assign rem_shift = {rem, mag[wd_pkg::AGG_BITS-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});
  assign quotient  = neg ? -$signed(mag) : $signed(mag);

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    start_div   = 1'b0;
    unique case (state)
      wd_pkg::BK_IDLE: begin
        if (!head_empty) begin
          if (head.avg) begin
            pop        = 1'b1;
            start_div  = 1'b1;
            state_next = wd_pkg::BK_DIV;
          end else if (out_free) begin
            pop         = 1'b1;
            load_direct = 1'b1;
          end
        end
      end
      wd_pkg::BK_DIV: begin
        if (step == STEP_BITS'(wd_pkg::AGG_BITS - 1)) state_next = wd_pkg::BK_DONE;
      end
      wd_pkg::BK_DONE: begin
        if (out_free) begin
          load_div   = 1'b1;
          state_next = wd_pkg::BK_IDLE;
        end
      end
      default: state_next = wd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wd_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct || load_div) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      neg       <= head.agg[wd_pkg::AGG_BITS-1];
      mag       <= head.agg[wd_pkg::AGG_BITS-1] ? -head.agg : head.agg;
      rem       <= '0;
      divisor   <= (head.cnt == '0) ? wd_pkg::COUNT_BITS'(1) : head.cnt;
      step      <= '0;
      hold_time <= head.tstamp;
      hold_ovf  <= head.ovf;
      hold_last <= head.last;
    end else if (state == wd_pkg::BK_DIV) begin
      rem  <= q_bit ? rem_shift[wd_pkg::COUNT_BITS-1:0] - divisor
                    : rem_shift[wd_pkg::COUNT_BITS-1:0];
      mag  <= {mag[wd_pkg::AGG_BITS-2:0], q_bit};
      step <= step + STEP_BITS'(1);
    end

    if (load_direct) begin
      results.out_time       <= head.tstamp;
      results.out_value      <= clamp_value(head.agg);
      results.out_last       <= head.last;
      results.count_overflow <= head.ovf;
    end else if (load_div) begin
      results.out_time       <= hold_time;
      results.out_value      <= clamp_value(quotient);
      results.out_last       <= hold_last;
      results.count_overflow <= hold_ovf;
    end
  end

endmodule

FILE: rtl/core/window_decimator.sv
// path: front end, 4-entry queue, then the back end's output register; a window
// average also passes the bit-serial divider, which takes one average at a time
// throughput: one sample per cycle while the queue has room and no result waits;
// a beat with two results holds off the next sample until its second is queued
// reset: synchronous; clears registers to mode 0, every_n 10, window_ms 1000,
// no window open, and empties the queue and the output register
module window_decimator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  wd_in_if.sink                             samples,
  wd_out_if.source                          results
);

  wd_pkg::wd_cmd_t push_cmd;
  wd_pkg::wd_cmd_t head_cmd;
  logic            push_valid;
  logic            queue_full;
  logic            queue_empty;
  logic            queue_pop;

  wd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .cmd       (push_cmd),
    .cmd_valid (push_valid),
    .cmd_room  (!queue_full)
  );

  wd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (head_cmd),
    .empty     (queue_empty)
  );

  wd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_cmd),
    .head_empty (queue_empty),
    .pop        (queue_pop),
    .results    (results)
  );

endmodule
